[hdl/clws_pkg.sv]
// ----------------------------------------------------------------------------
// clws_pkg
// Shared types, codes and tables of the character LCD write sequencer.
// ----------------------------------------------------------------------------
package clws_pkg;

  // Request codes (tuser of the input stream)
  typedef enum logic [2:0] {
    FN_CMD   = 3'd0,
    FN_DATA  = 3'd1,
    FN_GOTO  = 3'd2,
    FN_INIT  = 3'd3,
    FN_NUM   = 3'd4,
    FN_GLYPH = 3'd5
  } func_t;

  // Register indexes on the APB port
  localparam logic [1:0] REG_FOUR_BIT = 2'd0;
  localparam logic [1:0] REG_PULSE    = 2'd1;
  localparam logic [1:0] REG_SETTLE   = 2'd2;
  localparam logic [1:0] REG_POWERUP  = 2'd3;

  localparam logic       RST_FOUR_BIT = 1'b1;
  localparam logic [7:0] RST_PULSE    = 8'd1;
  localparam logic [7:0] RST_SETTLE   = 8'd5;
  localparam logic [7:0] RST_POWERUP  = 8'd100;

  localparam logic [7:0] CMD_FUNC_8BIT = 8'h38;
  localparam logic [7:0] CMD_HOME      = 8'h02;
  localparam logic [7:0] ASCII_ZERO    = 8'h30;

  localparam int NUM_DIGITS = 10;
  localparam int NUM_BITS   = 32;
  localparam int OUT_BITS   = 18;

  // Where the byte of one transfer comes from
  typedef enum logic [2:0] {
    SRC_BVAL  = 3'd0,
    SRC_GOTO  = 3'd1,
    SRC_SLOT  = 3'd2,
    SRC_CGRAM = 3'd3,
    SRC_PAT   = 3'd4,
    SRC_CONST = 3'd5,
    SRC_DIGIT = 3'd6
  } src_t;

  typedef struct packed {
    src_t       src;
    logic [7:0] cbyte;
    logic       rs;
    logic       last;
  } step_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;
    logic       conv_shift;
    logic       scan_step;
    logic       digit_next;
    logic       emit;
    logic       emit_wait;
    src_t       src;
    logic [7:0] cbyte;
    logic       rs;
    logic [2:0] pat_idx;
    logic [1:0] ph;
    logic       last;
  } clws_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic four_bit;
    logic slot_small;
    logic lead_found;
    logic digit_last;
    logic out_free;
  } clws_stat_t;

  function automatic logic [7:0] row_base(input logic [1:0] r);
    logic [7:0] v;
    case (r)
      2'd0:    v = 8'h80;
      2'd1:    v = 8'hC0;
      2'd2:    v = 8'h94;
      default: v = 8'hD4;
    endcase
    return v;
  endfunction

  // 4-bit init command list; the 8-bit list is 0x38 then entries 3..6
  function automatic logic [7:0] init_byte(input logic [2:0] i);
    logic [7:0] v;
    case (i)
      3'd0:    v = 8'h33;
      3'd1:    v = 8'h32;
      3'd2:    v = 8'h28;
      3'd3:    v = 8'h0C;
      3'd4:    v = 8'h02;
      3'd5:    v = 8'h01;
      default: v = 8'h06;
    endcase
    return v;
  endfunction

  // Byte transfer number 'step' of a request
  function automatic step_t step_desc(input logic [2:0] fn, input logic four_bit,
                                      input logic slot_small, input logic [3:0] step);
    step_t d;
    logic [3:0] idx;
    d.src   = SRC_CONST;
    d.cbyte = 8'h00;
    d.rs    = 1'b0;
    d.last  = 1'b1;
    idx     = step + 4'd2;
    case (fn)
      FN_CMD:  d.src = SRC_BVAL;
      FN_DATA: begin
        d.src = SRC_BVAL;
        d.rs  = 1'b1;
      end
      FN_GOTO: d.src = SRC_GOTO;
      FN_INIT: begin
        if (four_bit) begin
          d.cbyte = init_byte(step[2:0]);
          d.last  = (step == 4'd6);
        end else begin
          d.cbyte = (step == 4'd0) ? CMD_FUNC_8BIT : init_byte(idx[2:0]);
          d.last  = (step == 4'd4);
        end
      end
      FN_NUM: begin
        d.src  = SRC_DIGIT;
        d.rs   = 1'b1;
        d.last = 1'b0;
      end
      FN_GLYPH: begin
        d.last = 1'b0;
        if (step == 4'd0) begin
          d.src = SRC_GOTO;
        end else if (step == 4'd1) begin
          d.src = SRC_SLOT;
          d.rs  = 1'b1;
        end else if (slot_small && step == 4'd2) begin
          d.src = SRC_CGRAM;
        end else if (slot_small && step >= 4'd3 && step <= 4'd10) begin
          d.src = SRC_PAT;
          d.rs  = 1'b1;
        end else begin
          d.cbyte = CMD_HOME;
          d.last  = 1'b1;
        end
      end
      default: d.last = 1'b1;
    endcase
    return d;
  endfunction

endpackage

[hdl/clws_dp.sv]
// ----------------------------------------------------------------------------
// clws_dp
// Datapath: config registers, request latch, binary to BCD converter,
// byte select and phase output register.
// ----------------------------------------------------------------------------
module clws_dp import clws_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // APB
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  // request fields
  input  logic [7:0]   in_bval,
  input  logic [1:0]   in_row,
  input  logic [5:0]   in_col,
  input  logic [31:0]  in_number,
  input  logic [63:0]  in_pat,
  input  logic [7:0]   in_slot,
  // phase output
  output logic         out_valid,
  input  logic         out_ready,
  output logic [OUT_BITS-1:0] out_data,
  output logic         out_last,
  // controller link
  input  clws_cmd_t    cmd,
  output clws_stat_t   stat
);

  logic       four_bit;
  logic [7:0] pulse_ms, settle_ms, powerup_ms;

  logic [7:0]  bval, slot;
  logic [1:0]  row;
  logic [5:0]  col;
  logic [63:0] pat;

  logic [NUM_BITS-1:0] bin;
  logic [3:0] bcd [NUM_DIGITS];
  logic [3:0] adj [NUM_DIGITS];
  logic [3:0] ptr;

  logic [7:0] b;
  logic [7:0] bus;
  logic       en;
  logic [7:0] hold;
  logic       wr;

  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      four_bit   <= RST_FOUR_BIT;
      pulse_ms   <= RST_PULSE;
      settle_ms  <= RST_SETTLE;
      powerup_ms <= RST_POWERUP;
    end else if (wr) begin
      case (paddr[3:2])
        REG_FOUR_BIT: four_bit   <= pwdata[0];
        REG_PULSE:    pulse_ms   <= pwdata[7:0];
        REG_SETTLE:   settle_ms  <= pwdata[7:0];
        REG_POWERUP:  powerup_ms <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FOUR_BIT: prdata = {31'd0, four_bit};
      REG_PULSE:    prdata = {24'd0, pulse_ms};
      REG_SETTLE:   prdata = {24'd0, settle_ms};
      REG_POWERUP:  prdata = {24'd0, powerup_ms};
      default:      prdata = 32'd0;
    endcase
  end

  // double dabble: add 3 to digits of 5 or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bval <= in_bval;
      row  <= in_row;
      col  <= in_col;
      pat  <= in_pat;
      slot <= in_slot;
      bin  <= in_number;
      ptr  <= 4'(NUM_DIGITS - 1);
      for (int i = 0; i < NUM_DIGITS; i++) bcd[i] <= 4'd0;
    end else if (cmd.conv_shift) begin
      bin <= {bin[NUM_BITS-2:0], 1'b0};
      bcd[0] <= {adj[0][2:0], bin[NUM_BITS-1]};
      for (int i = 1; i < NUM_DIGITS; i++) bcd[i] <= {adj[i][2:0], adj[i-1][3]};
    end else if (cmd.scan_step || cmd.digit_next) begin
      ptr <= ptr - 4'd1;
    end
  end

  always_comb begin
    case (cmd.src)
      SRC_BVAL:  b = bval;
      SRC_GOTO:  b = row_base(row) + {2'b00, col};
      SRC_SLOT:  b = slot;
      SRC_CGRAM: b = {2'b01, slot[2:0], 3'b000};
      SRC_PAT:   b = pat[{cmd.pat_idx, 3'b000} +: 8];
      SRC_DIGIT: b = ASCII_ZERO | {4'h0, bcd[ptr]};
      default:   b = cmd.cbyte;
    endcase
  end

  // 4-bit: hi strobe, hi release, lo strobe, lo release
  always_comb begin
    if (four_bit) begin
      bus  = cmd.ph[1] ? {b[3:0], 4'h0} : {b[7:4], 4'h0};
      hold = cmd.ph[0] ? (cmd.ph[1] ? settle_ms : 8'd0) : pulse_ms;
    end else begin
      bus  = b;
      hold = cmd.ph[0] ? settle_ms : pulse_ms;
    end
    en = ~cmd.ph[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_wait) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_wait) begin
      out_data <= {powerup_ms, 1'b0, 8'h00, 1'b0};
      out_last <= 1'b0;
    end else if (cmd.emit) begin
      out_data <= {hold, en, bus, cmd.rs};
      out_last <= cmd.last;
    end
  end

  assign stat.four_bit   = four_bit;
  assign stat.slot_small = (slot < 8'd8);
  assign stat.lead_found = (bcd[ptr] != 4'd0) || (ptr == 4'd0);
  assign stat.digit_last = (ptr == 4'd0);
  assign stat.out_free   = ~out_valid | out_ready;

endmodule

[hdl/clws_ctrl.sv]
// ----------------------------------------------------------------------------
// clws_ctrl
// Controller: walks the byte transfers and strobe phases of one request.
// ----------------------------------------------------------------------------
module clws_ctrl import clws_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_func,
  input  logic        in_neg,
  output clws_cmd_t   cmd,
  input  clws_stat_t  stat
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_WAIT  = 5'b01000,
    ST_PHASE = 5'b10000
  } state_t;

  state_t     state, state_next;
  logic [2:0] func, func_next;
  logic [3:0] step, step_next;
  logic [1:0] ph, ph_next;
  logic [4:0] conv_cnt, conv_cnt_next;

  step_t      d;
  logic       last_step;
  logic       final_ph;
  logic [3:0] pidx;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    d         = step_desc(func, stat.four_bit, stat.slot_small, step);
    last_step = d.last || (func == FN_NUM && stat.digit_last);
    final_ph  = stat.four_bit ? (ph == 2'd3) : (ph == 2'd1);
    pidx      = step - 4'd3;
  end

  always_comb begin
    state_next    = state;
    func_next     = func;
    step_next     = step;
    ph_next       = ph;
    conv_cnt_next = conv_cnt;

    cmd            = '0;
    cmd.src        = d.src;
    cmd.cbyte      = d.cbyte;
    cmd.rs         = d.rs;
    cmd.pat_idx    = pidx[2:0];
    cmd.ph         = ph;
    cmd.last       = last_step && final_ph;

    case (state)
      ST_IDLE: begin
        step_next     = 4'd0;
        ph_next       = 2'd0;
        conv_cnt_next = 5'd0;
        if (in_valid) begin
          cmd.load  = 1'b1;
          func_next = in_func;
          case (in_func)
            FN_CMD, FN_DATA, FN_GOTO, FN_GLYPH: state_next = ST_PHASE;
            FN_INIT: state_next = ST_WAIT;
            FN_NUM:  state_next = in_neg ? ST_IDLE : ST_CONV;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CONV: begin
        cmd.conv_shift = 1'b1;
        conv_cnt_next  = conv_cnt + 5'd1;
        if (conv_cnt == 5'(NUM_BITS - 1)) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        // drop leading zero digits, one per cycle
        if (stat.lead_found) state_next = ST_PHASE;
        else cmd.scan_step = 1'b1;
      end
      ST_WAIT: begin
        if (stat.out_free) begin
          cmd.emit_wait = 1'b1;
          state_next    = ST_PHASE;
        end
      end
      ST_PHASE: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (final_ph) begin
            ph_next = 2'd0;
            if (last_step) begin
              state_next = ST_IDLE;
            end else begin
              step_next      = step + 4'd1;
              cmd.digit_next = (func == FN_NUM);
            end
          end else begin
            ph_next = ph + 2'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      func     <= FN_CMD;
      step     <= 4'd0;
      ph       <= 2'd0;
      conv_cnt <= 5'd0;
    end else begin
      state    <= state_next;
      func     <= func_next;
      step     <= step_next;
      ph       <= ph_next;
      conv_cnt <= conv_cnt_next;
    end
  end

endmodule

[hdl/character_lcd_write_sequencer.sv]
// Flow: an accepted request goes to ST_PHASE, which registers each phase for the output;
//   an init request first passes ST_WAIT, a number request ST_CONV (binary to BCD) and ST_SCAN.
// Throughput: one phase per cycle while the sink is ready; one request at a time,
//   so a new request is taken only after the previous one emits its last phase (up to 48 phases).
// Reset: config registers return to 4-bit mode, 1/5/100 ms; controller idle,
//   output register empty.
// ----------------------------------------------------------------------------
// character_lcd_write_sequencer
// Expands LCD requests into timed register-select / bus / enable phases.
// ----------------------------------------------------------------------------
module character_lcd_write_sequencer import clws_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  // request stream
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // byte_value[7:0], row[9:8], column[15:10], number[47:16],
  // glyph_pattern[111:48], glyph_slot[119:112]
  input  logic [119:0]  s_axis_tdata,
  // func[2:0]
  input  logic [2:0]    s_axis_tuser,
  // phase stream
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // select_data[0], bus_value[8:1], enable[9], hold_ms[17:10], zero[23:18]
  output logic [23:0]   m_axis_tdata,
  output logic          m_axis_tlast,
  // APB config
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  clws_cmd_t  cmd;
  clws_stat_t stat;
  logic [OUT_BITS-1:0] out_data;

  assign pready = 1'b1;
  assign m_axis_tdata = {6'd0, out_data};

  clws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_func  (s_axis_tuser),
    .in_neg   (s_axis_tdata[47]),
    .cmd      (cmd),
    .stat     (stat)
  );

  clws_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_bval   (s_axis_tdata[7:0]),
    .in_row    (s_axis_tdata[9:8]),
    .in_col    (s_axis_tdata[15:10]),
    .in_number (s_axis_tdata[47:16]),
    .in_pat    (s_axis_tdata[111:48]),
    .in_slot   (s_axis_tdata[119:112]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_data),
    .out_last  (m_axis_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the character LCD write sequencer. A short table of
// directed requests runs first, then constrained-by-hand random requests
// across several register settings. Every phase leaving the block is checked
// field by field against typed-in phases or an in-bench expansion of the request.
// ----------------------------------------------------------------------------
module tb_top;
  import clws_pkg::*;

  localparam int DRAIN_CYCLES    = 64;   // covers the number conversion latency
  localparam int RANDOM_REQUESTS = 145;
  localparam int RECONFIG_EVERY  = 35;
  localparam int LONG_HOLD       = 400;
  localparam int HOLD_AFTER      = 400;

  // Unused request codes, the block drops them
  localparam logic [2:0] FN_NONE_A = 3'd6;
  localparam logic [2:0] FN_NONE_B = 3'd7;

  localparam logic [7:0] CMD_WAKE_A     = 8'h33;
  localparam logic [7:0] CMD_WAKE_B     = 8'h32;
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h0C;
  localparam logic [7:0] CMD_CLEAR      = 8'h01;
  localparam logic [7:0] CMD_ENTRY      = 8'h06;
  localparam logic [7:0] CMD_CGRAM      = 8'h40;
  localparam logic [3:0][7:0] ROW_BASE  = {8'hD4, 8'h94, 8'hC0, 8'h80};

  // Same layout as s_axis_tdata, lowest field last
  typedef struct packed {
    logic [7:0]  slot;
    logic [63:0] pattern;
    logic [31:0] number;
    logic [5:0]  column;
    logic [1:0]  row;
    logic [7:0]  byte_value;
  } req_fields_t;

  typedef struct packed {
    logic [2:0]  func;
    req_fields_t f;
  } request_t;

  typedef struct packed {
    logic       sel;
    logic [7:0] bus;
    logic       en;
    logic [7:0] hold;
    logic       last;
  } phase_t;

  typedef struct {
    logic       is_cfg;
    logic [1:0] reg_idx;
    logic [7:0] reg_val;
    request_t   req;
    int         n_typed;   // -1: expectation comes from the expansion
  } stim_row_t;

  logic         clk           = 1'b0;
  logic         rst           = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [119:0] s_axis_tdata  = '0;
  logic [2:0]   s_axis_tuser  = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [23:0]  m_axis_tdata;
  logic         m_axis_tlast;
  logic         psel          = 1'b0;
  logic         penable       = 1'b0;
  logic         pwrite        = 1'b0;
  logic [3:0]   paddr         = '0;
  logic [31:0]  pwdata        = '0;
  logic [31:0]  prdata;
  logic         pready;

  // Bench copy of the register file
  logic       mdl_four_bit = RST_FOUR_BIT;
  logic [7:0] mdl_pulse    = RST_PULSE;
  logic [7:0] mdl_settle   = RST_SETTLE;
  logic [7:0] mdl_powerup  = RST_POWERUP;

  phase_t    lcd_phases_due[$];
  phase_t    typed_phases[$];
  stim_row_t directed_rows[$];

  int  err_count      = 0;
  int  requests_sent  = 0;
  int  phases_seen    = 0;
  int  cfg_writes     = 0;
  int  tx_calm        = 0;
  int  rx_calm        = 0;
  bit  long_hold_done = 1'b0;

  character_lcd_write_sequencer u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endfunction

  // Wait before an item: mostly random, with occasional runs of back-to-back items
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 17);
  endfunction

  function automatic void due_phase(logic sel, logic [7:0] bus, logic en, logic [7:0] hold);
    lcd_phases_due.push_back(phase_t'{sel, bus, en, hold, 1'b0});
  endfunction

  function automatic void due_byte(logic sel, logic [7:0] b);
    if (mdl_four_bit) begin
      due_phase(sel, {b[7:4], 4'h0}, 1'b1, mdl_pulse);
      due_phase(sel, {b[7:4], 4'h0}, 1'b0, 8'd0);
      due_phase(sel, {b[3:0], 4'h0}, 1'b1, mdl_pulse);
      due_phase(sel, {b[3:0], 4'h0}, 1'b0, mdl_settle);
    end else begin
      due_phase(sel, b, 1'b1, mdl_pulse);
      due_phase(sel, b, 1'b0, mdl_settle);
    end
  endfunction

  function automatic void expand_request(request_t r);
    int         base;
    int         nd;
    int         k;
    logic [31:0] v;
    logic [7:0] digs[10];
    logic [7:0] goto_cmd;
    phase_t     p;
    base     = lcd_phases_due.size();
    goto_cmd = ROW_BASE[r.f.row] + 8'(r.f.column);   // wraps mod 256
    case (r.func)
      FN_CMD:   due_byte(1'b0, r.f.byte_value);
      FN_DATA:  due_byte(1'b1, r.f.byte_value);
      FN_GOTO:  due_byte(1'b0, goto_cmd);
      FN_INIT: begin
        due_phase(1'b0, 8'h00, 1'b0, mdl_powerup);
        if (mdl_four_bit) begin
          due_byte(1'b0, CMD_WAKE_A);
          due_byte(1'b0, CMD_WAKE_B);
          due_byte(1'b0, CMD_FUNC_4BIT);
        end else begin
          due_byte(1'b0, CMD_FUNC_8BIT);
        end
        due_byte(1'b0, CMD_DISPLAY_ON);
        due_byte(1'b0, CMD_HOME);
        due_byte(1'b0, CMD_CLEAR);
        due_byte(1'b0, CMD_ENTRY);
      end
      FN_NUM: begin
        v = r.f.number;
        if (v == 32'd0) begin
          due_byte(1'b1, ASCII_ZERO);
        end else if (!v[31]) begin
          nd = 0;
          while (v != 32'd0) begin
            digs[nd] = 8'(v % 32'd10);
            v = v / 32'd10;
            nd++;
          end
          while (nd > 0) begin
            nd--;
            due_byte(1'b1, ASCII_ZERO + digs[nd]);
          end
        end
      end
      FN_GLYPH: begin
        due_byte(1'b0, goto_cmd);
        due_byte(1'b1, r.f.slot);
        if (r.f.slot < 8'd8) begin
          due_byte(1'b0, CMD_CGRAM | {2'b00, r.f.slot[2:0], 3'b000});
          for (k = 0; k < 8; k++) due_byte(1'b1, r.f.pattern[8*k +: 8]);
        end
        due_byte(1'b0, CMD_HOME);
      end
      default: ;
    endcase
    if (lcd_phases_due.size() > base) begin
      p = lcd_phases_due.pop_back();
      p.last = 1'b1;
      lcd_phases_due.push_back(p);
    end
  endfunction

  function automatic request_t mk_req(logic [2:0] fn, logic [7:0] bv, logic [1:0] rw,
                                      logic [5:0] col, logic [31:0] num, logic [63:0] pat,
                                      logic [7:0] slot);
    request_t r;
    r.func         = fn;
    r.f.byte_value = bv;
    r.f.row        = rw;
    r.f.column     = col;
    r.f.number     = num;
    r.f.pattern    = pat;
    r.f.slot       = slot;
    return r;
  endfunction

  function automatic void add_row(request_t r, int n_typed);
    directed_rows.push_back('{1'b0, 2'd0, 8'd0, r, n_typed});
  endfunction

  function automatic void add_cfg(logic [1:0] idx, logic [7:0] val);
    directed_rows.push_back('{1'b1, idx, val, '0, 0});
  endfunction

  function automatic void typed(logic sel, logic [7:0] bus, logic en, logic [7:0] hold,
                                logic last);
    typed_phases.push_back(phase_t'{sel, bus, en, hold, last});
  endfunction

  function automatic request_t rand_request();
    request_t r;
    int       k;
    r.f.byte_value = 8'($urandom);
    r.f.row        = 2'($urandom);
    r.f.column     = 6'($urandom);
    r.f.pattern    = {$urandom, $urandom};
    r.f.slot       = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    case ($urandom_range(0, 3))
      0:       r.f.number = $urandom;
      1:       r.f.number = $urandom_range(0, 99);
      2:       r.f.number = $urandom_range(0, 99999);
      default: r.f.number = $urandom & 32'h7FFF_FFFF;
    endcase
    k = $urandom_range(0, 99);
    if (k < 4)       r.func = $urandom_range(0, 1) ? FN_NONE_B : FN_NONE_A;
    else if (k < 19) r.func = FN_CMD;
    else if (k < 34) r.func = FN_DATA;
    else if (k < 49) r.func = FN_GOTO;
    else if (k < 57) r.func = FN_INIT;
    else if (k < 77) r.func = FN_NUM;
    else             r.func = FN_GLYPH;
    return r;
  endfunction

  function automatic logic [31:0] model_register(logic [1:0] idx);
    case (idx)
      REG_FOUR_BIT: return {31'd0, mdl_four_bit};
      REG_PULSE:    return {24'd0, mdl_pulse};
      REG_SETTLE:   return {24'd0, mdl_settle};
      default:      return {24'd0, mdl_powerup};
    endcase
  endfunction

  function automatic logic [7:0] rand_reg_value();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic apb_access(input logic wr, input logic [1:0] idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(input logic [1:0] idx);
    logic [31:0] rd;
    apb_access(1'b0, idx, 32'd0, rd);
    check_field("prdata", model_register(idx), rd);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] val);
    logic [31:0] rd;
    case (idx)
      REG_FOUR_BIT: mdl_four_bit = val[0];
      REG_PULSE:    mdl_pulse    = val;
      REG_SETTLE:   mdl_settle   = val;
      default:      mdl_powerup  = val;
    endcase
    apb_access(1'b1, idx, model_register(idx), rd);
    check_register(idx);
    cfg_writes++;
  endtask

  // Registers only change with nothing in flight
  task automatic drain_block();
    s_axis_tvalid <= 1'b0;
    while (lcd_phases_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_request(input request_t r, input int n_typed);
    int gap;
    gap = draw_wait(tx_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= r.f;
    s_axis_tuser  <= r.func;
    do @(posedge clk); while (!s_axis_tready);
    if (n_typed < 0) expand_request(r);
    else repeat (n_typed) lcd_phases_due.push_back(typed_phases.pop_front());
    requests_sent++;
  endtask

  initial begin : phase_sink
    int     stall;
    phase_t want;
    phase_t got;
    wait (!rst);
    @(posedge clk);
    forever begin
      // one long back-pressure window so the request side fills up and stalls
      if (!long_hold_done && phases_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        stall = LONG_HOLD;
      end else begin
        stall = draw_wait(rx_calm);
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      got = phase_t'{m_axis_tdata[0], m_axis_tdata[8:1], m_axis_tdata[9],
                     m_axis_tdata[17:10], m_axis_tlast};
      phases_seen++;
      if (lcd_phases_due.size() == 0) begin
        $error("unexpected phase: tdata 0x%0h tlast %b", m_axis_tdata, m_axis_tlast);
        err_count++;
      end else begin
        want = lcd_phases_due.pop_front();
        check_field("select_data", want.sel,  got.sel);
        check_field("bus_value",   want.bus,  got.bus);
        check_field("enable",      want.en,   got.en);
        check_field("hold_ms",     want.hold, got.hold);
        check_field("last",        want.last, got.last);
      end
    end
  end

  initial begin : stimulus
    request_t  r;
    stim_row_t sr;
    int        n_counted;
    int        i;

    // After reset: 4-bit bus, pulse 1 ms, settle 5 ms
    add_row(mk_req(FN_CMD, 8'h00, 2'd0, 6'd0, 32'd0, 64'd0, 8'd0), 4);
    typed(1'b0, 8'h00, 1'b1, 8'd1, 1'b0);
    typed(1'b0, 8'h00, 1'b0, 8'd0, 1'b0);
    typed(1'b0, 8'h00, 1'b1, 8'd1, 1'b0);
    typed(1'b0, 8'h00, 1'b0, 8'd5, 1'b1);
    add_row(mk_req(FN_DATA, 8'hFF, 2'd3, 6'd63, 32'hFFFF_FFFF, '1, 8'hFF), 4);
    typed(1'b1, 8'hF0, 1'b1, 8'd1, 1'b0);
    typed(1'b1, 8'hF0, 1'b0, 8'd0, 1'b0);
    typed(1'b1, 8'hF0, 1'b1, 8'd1, 1'b0);
    typed(1'b1, 8'hF0, 1'b0, 8'd5, 1'b1);
    // goto past the end of the address space wraps: 0xD4 + 63 -> 0x13
    add_row(mk_req(FN_GOTO, 8'h00, 2'd3, 6'd63, 32'd0, 64'd0, 8'd0), 4);
    typed(1'b0, 8'h10, 1'b1, 8'd1, 1'b0);
    typed(1'b0, 8'h10, 1'b0, 8'd0, 1'b0);
    typed(1'b0, 8'h30, 1'b1, 8'd1, 1'b0);
    typed(1'b0, 8'h30, 1'b0, 8'd5, 1'b1);
    // negatives and unused codes produce nothing
    add_row(mk_req(FN_NUM, 8'hFF, 2'd3, 6'd63, 32'hFFFF_FFFF, '1, 8'hFF), 0);
    add_row(mk_req(FN_NUM, 8'h00, 2'd0, 6'd0, 32'h8000_0000, 64'd0, 8'd0), 0);
    add_row(mk_req(FN_NONE_A, 8'hFF, 2'd3, 6'd63, 32'd0, '1, 8'h00), 0);
    add_row(mk_req(FN_NONE_B, 8'h00, 2'd0, 6'd0, 32'd5, 64'd0, 8'hFF), 0);
    // zero shows a single '0'
    add_row(mk_req(FN_NUM, 8'h00, 2'd0, 6'd0, 32'd0, 64'd0, 8'd0), 4);
    typed(1'b1, 8'h30, 1'b1, 8'd1, 1'b0);
    typed(1'b1, 8'h30, 1'b0, 8'd0, 1'b0);
    typed(1'b1, 8'h00, 1'b1, 8'd1, 1'b0);
    typed(1'b1, 8'h00, 1'b0, 8'd5, 1'b1);
    add_row(mk_req(FN_NUM, 8'h00, 2'd0, 6'd0, 32'h7FFF_FFFF, 64'd0, 8'd0), -1);
    add_row(mk_req(FN_NUM, 8'h00, 2'd0, 6'd0, 32'd1000000000, 64'd0, 8'd0), -1);
    add_row(mk_req(FN_INIT, 8'h00, 2'd0, 6'd0, 32'd0, 64'd0, 8'd0), -1);
    add_row(mk_req(FN_GLYPH, 8'h00, 2'd0, 6'd0, 32'd0, '1, 8'd0), -1);
    add_row(mk_req(FN_GLYPH, 8'h00, 2'd2, 6'd5, 32'd0, 64'h0123_4567_89AB_CDEF, 8'd7), -1);
    add_row(mk_req(FN_GLYPH, 8'h00, 2'd1, 6'd63, 32'd0, '1, 8'd8), -1);
    add_row(mk_req(FN_GLYPH, 8'h00, 2'd3, 6'd0, 32'd0, 64'd0, 8'hFF), -1);
    add_row(mk_req(FN_GOTO, 8'h00, 2'd1, 6'd0, 32'd0, 64'd0, 8'd0), -1);
    // 8-bit bus, widest pulse, no settle, longest power-up wait
    add_cfg(REG_FOUR_BIT, 8'd0);
    add_cfg(REG_PULSE, 8'hFF);
    add_cfg(REG_SETTLE, 8'h00);
    add_cfg(REG_POWERUP, 8'hFF);
    add_row(mk_req(FN_CMD, 8'hA5, 2'd0, 6'd0, 32'd0, 64'd0, 8'd0), 2);
    typed(1'b0, 8'hA5, 1'b1, 8'hFF, 1'b0);
    typed(1'b0, 8'hA5, 1'b0, 8'h00, 1'b1);
    add_row(mk_req(FN_INIT, 8'h00, 2'd0, 6'd0, 32'd0, 64'd0, 8'd0), -1);
    add_row(mk_req(FN_DATA, 8'h5A, 2'd0, 6'd0, 32'd0, 64'd0, 8'd0), -1);
    add_row(mk_req(FN_NUM, 8'h00, 2'd0, 6'd0, 32'd9, 64'd0, 8'd0), -1);
    add_row(mk_req(FN_GLYPH, 8'h00, 2'd2, 6'd40, 32'd0, 64'hA55A_0FF0_3CC3_6996, 8'd3), -1);
    add_row(mk_req(FN_GOTO, 8'h00, 2'd0, 6'd63, 32'd0, 64'd0, 8'd0), -1);
    // back to 4-bit with zero pulse and power-up, longest settle
    add_cfg(REG_PULSE, 8'h00);
    add_cfg(REG_SETTLE, 8'hFF);
    add_cfg(REG_POWERUP, 8'h00);
    add_cfg(REG_FOUR_BIT, 8'd1);
    add_row(mk_req(FN_INIT, 8'h00, 2'd0, 6'd0, 32'd0, 64'd0, 8'd0), -1);
    add_row(mk_req(FN_DATA, 8'h80, 2'd0, 6'd0, 32'd0, 64'd0, 8'd0), 4);
    typed(1'b1, 8'h80, 1'b1, 8'h00, 1'b0);
    typed(1'b1, 8'h80, 1'b0, 8'h00, 1'b0);
    typed(1'b1, 8'h00, 1'b1, 8'h00, 1'b0);
    typed(1'b1, 8'h00, 1'b0, 8'hFF, 1'b1);
    add_row(mk_req(FN_NUM, 8'h00, 2'd0, 6'd0, 32'd42, 64'd0, 8'd0), -1);

    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (i = 0; i < 4; i++) check_register(2'(i));

    foreach (directed_rows[j]) begin
      sr = directed_rows[j];
      if (sr.is_cfg) begin
        drain_block();
        write_register(sr.reg_idx, sr.reg_val);
      end else begin
        send_request(sr.req, sr.n_typed);
      end
    end

    n_counted = 0;
    while (n_counted < RANDOM_REQUESTS) begin
      r = rand_request();
      send_request(r, -1);
      if (r.func <= FN_GLYPH) begin
        n_counted++;
        if (n_counted % RECONFIG_EVERY == 0 && n_counted < RANDOM_REQUESTS) begin
          drain_block();
          for (i = 0; i < 4; i++) write_register(2'(i), rand_reg_value());
        end
      end
    end

    drain_block();
    $display("tb: %0d requests sent, %0d LCD phases checked, %0d register writes",
             requests_sent, phases_seen, cfg_writes);
    $display("tb: both bus widths, every request kind, zero/negative numbers, glyph loads");
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
